// ----- hw/rtl/pjb_pkg.sv -----
// ----------------------------------------------------------------------------
// Playout jitter buffer package
// Field widths, request codes, register indexes and reset values shared by
// the jitter buffer modules.
// ----------------------------------------------------------------------------
package pjb_pkg;

  localparam int KIND_W     = 8;
  localparam int STAMP_W    = 8;
  localparam int SIZE_W     = 12;
  localparam int HANDLE_W   = 16;
  localparam int FRAME_W    = 16;
  localparam int SLOT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_PLAYOUT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd1;

  localparam logic [SIZE_W-1:0]  HEADER_BYTES  = 12'd2;
  localparam logic [KIND_W-1:0]  SIGNATURE_RST = 8'd0;
  localparam logic [FRAME_W-1:0] FRAME_RST     = 16'd512;

endpackage

// ----- hw/rtl/pjb_slot_ram.sv -----
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pjb_slot_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 29
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pjb_copy_len.sv -----
// ----------------------------------------------------------------------------
// Copy length unit
// Strips the packet header from the stored size and clips the result to the
// configured frame size.
// ----------------------------------------------------------------------------
module pjb_copy_len (
  input  logic [pjb_pkg::SIZE_W-1:0]  size_i,
  input  logic [pjb_pkg::FRAME_W-1:0] frame_i,
  output logic [pjb_pkg::FRAME_W-1:0] copy_o
);
  import pjb_pkg::*;

  logic [SIZE_W-1:0]  pay;
  logic [FRAME_W-1:0] pay_ext;

  assign pay     = (size_i >= HEADER_BYTES) ? (size_i - HEADER_BYTES) : '0;
  assign pay_ext = FRAME_W'(pay);
  assign copy_o  = (pay_ext > frame_i) ? frame_i : pay_ext;

endmodule

// ----- hw/rtl/packet_playout_jitter_buffer.sv -----
// ----------------------------------------------------------------------------
// Packet playout jitter buffer
// Slot table indexed by packet sequence stamp, with a sequenced playout scan.
// ----------------------------------------------------------------------------
// Items enter on the in channel and one result per item leaves on the out
// channel, both with valid and ready. A request of type arrival stores the
// packet handle and size in the slot of its stamp when the type byte matches
// the signature register and the stamp is not behind the play pointer, and
// reports a replaced handle. A playout request moves the play pointer and
// scans the slot table, one slot per cycle, for the next stored packet.
// The table sits in a single-port-read memory; the scan reads one slot per
// cycle through it. An accepted arrival passes through ST_ARR to ST_FINISH,
// a rejected arrival goes straight to ST_FINISH, and a playout stays in
// ST_SCAN while it examines slots, at most SLOTS of them, then goes to
// ST_FINISH, where the result is loaded into the output register. One item
// is in work at a time; a new item is accepted once the previous result has
// been handed to the output register, so the receiver may hold the last
// result while the next item is processed. After reset the block sweeps the
// table in ST_CLEAR to clear every slot and keeps in_ready_o low meanwhile;
// configuration writes go through the cfg channel.
// ----------------------------------------------------------------------------
module packet_playout_jitter_buffer #(
  parameter int SLOTS       = 256,
  parameter int MAX_PACKET  = 2048,
  parameter int HANDLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pjb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pjb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [pjb_pkg::KIND_W-1:0]     packet_kind_i,
  input  logic [pjb_pkg::STAMP_W-1:0]    stamp_i,
  input  logic [pjb_pkg::SIZE_W-1:0]     packet_size_i,
  input  logic [pjb_pkg::HANDLE_W-1:0]   packet_handle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic                           replaced_o,
  output logic [pjb_pkg::HANDLE_W-1:0]   old_handle_o,
  output logic                           found_o,
  output logic [pjb_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [pjb_pkg::HANDLE_W-1:0]   play_handle_o,
  output logic [pjb_pkg::FRAME_W-1:0]    copy_bytes_o
);
  import pjb_pkg::*;

  localparam int PW     = $clog2(SLOTS);
  localparam int MAX_SZ = (MAX_PACKET > 4095) ? 4095 : MAX_PACKET;
  localparam int SW     = $clog2(MAX_SZ + 1);
  localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int EW     = 1 + SW + HW;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ARR    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  function automatic logic [PW-1:0] slot_of(input logic [STAMP_W-1:0] s);
    logic [31:0] v;
    v = 32'(s);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (32'(SLOTS) << k)) begin
        v = v - (32'(SLOTS) << k);
      end
    end
    return v[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  logic [2:0]          state_q, state_d;
  logic [PW-1:0]       clr_q, clr_d;
  logic [PW-1:0]       pp_q, pp_d;
  logic [PW-1:0]       last_q, last_d;
  logic                resync_q, resync_d;
  logic [KIND_W-1:0]   sig_q, sig_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic                out_valid_q, out_valid_d;

  logic [PW-1:0]       start_q, start_d;
  logic [PW-1:0]       chk_q, chk_d;
  logic [PW-1:0]       cnt_q, cnt_d;
  logic [PW-1:0]       idx_q, idx_d;
  logic [SW-1:0]       size_q, size_d;
  logic [HW-1:0]       hdl_q, hdl_d;

  logic                res_acc_q, res_acc_d;
  logic                res_rep_q, res_rep_d;
  logic [HANDLE_W-1:0] res_old_q, res_old_d;
  logic                res_found_q, res_found_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [HANDLE_W-1:0] res_hdl_q, res_hdl_d;
  logic [FRAME_W-1:0]  res_copy_q, res_copy_d;

  logic                acc_q, acc_d;
  logic                rep_q, rep_d;
  logic [HANDLE_W-1:0] old_q, old_d;
  logic                found_q, found_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [HANDLE_W-1:0] phdl_q, phdl_d;
  logic [FRAME_W-1:0]  copy_q, copy_d;

  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic                ram_re;
  logic [PW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  logic                in_hs;
  logic [PW-1:0]       in_idx;
  logic                in_match;
  logic [PW-1:0]       in_start;
  logic                rd_vld;
  logic [SW-1:0]       rd_size;
  logic [HW-1:0]       rd_hdl;
  logic [FRAME_W-1:0]  copy_len;
  logic                last_cnt;
  logic                load;

  pjb_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (PW),
    .DW    (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pjb_copy_len u_copy (
    .size_i  (SIZE_W'(rd_size)),
    .frame_i (frame_q),
    .copy_o  (copy_len)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_hs       = in_valid_i && in_ready_o;
  assign in_idx      = slot_of(stamp_i);
  assign in_match    = (packet_kind_i == sig_q) && (resync_q || (in_idx >= pp_q));
  assign in_start    = resync_q ? last_q : next_slot(pp_q);
  assign rd_vld      = ram_rdata[EW-1];
  assign rd_size     = ram_rdata[EW-2 -: SW];
  assign rd_hdl      = ram_rdata[HW-1:0];
  assign last_cnt    = (cnt_q == PW'(SLOTS - 1));
  assign load        = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pp_d        = pp_q;
    last_d      = last_q;
    resync_d    = resync_q;
    sig_d       = sig_q;
    frame_d     = frame_q;
    start_d     = start_q;
    chk_d       = chk_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    size_d      = size_q;
    hdl_d       = hdl_q;
    res_acc_d   = res_acc_q;
    res_rep_d   = res_rep_q;
    res_old_d   = res_old_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    res_hdl_d   = res_hdl_q;
    res_copy_d  = res_copy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    rep_d       = rep_q;
    old_d       = old_q;
    found_d     = found_q;
    slot_d      = slot_q;
    phdl_d      = phdl_q;
    copy_d      = copy_q;
    ram_we      = 1'b0;
    ram_waddr   = chk_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = chk_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SIGNATURE:   sig_d   = cfg_data_i[KIND_W-1:0];
        CFG_FRAME_BYTES: frame_d = cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
      acc_d       = res_acc_q;
      rep_d       = res_rep_q;
      old_d       = res_old_q;
      found_d     = res_found_q;
      slot_d      = res_slot_q;
      phdl_d      = res_hdl_q;
      copy_d      = res_copy_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == PW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + PW'(1);
        end
      end
      ST_IDLE: begin
        if (in_hs) begin
          res_acc_d   = 1'b0;
          res_rep_d   = 1'b0;
          res_old_d   = '0;
          res_found_d = 1'b0;
          res_slot_d  = '0;
          res_hdl_d   = '0;
          res_copy_d  = '0;
          idx_d       = in_idx;
          size_d      = (32'(packet_size_i) > MAX_SZ) ? SW'(MAX_SZ) : SW'(packet_size_i);
          hdl_d       = HW'(packet_handle_i);
          if (req_type_i == REQ_PLAYOUT) begin
            resync_d  = 1'b0;
            start_d   = in_start;
            chk_d     = in_start;
            cnt_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = in_start;
            state_d   = ST_SCAN;
          end else if (in_match) begin
            ram_re    = 1'b1;
            ram_raddr = in_idx;
            state_d   = ST_ARR;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ARR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {1'b1, size_q, hdl_q};
        res_acc_d = 1'b1;
        res_rep_d = rd_vld;
        res_old_d = rd_vld ? HANDLE_W'(rd_hdl) : '0;
        last_d    = idx_q;
        state_d   = ST_FINISH;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = next_slot(chk_q);
        if (rd_vld) begin
          ram_we      = 1'b1;
          ram_waddr   = chk_q;
          ram_wdata   = {1'b0, ram_rdata[EW-2:0]};
          res_found_d = 1'b1;
          res_slot_d  = SLOT_W'(chk_q);
          res_hdl_d   = HANDLE_W'(rd_hdl);
          res_copy_d  = copy_len;
          pp_d        = chk_q;
          state_d     = ST_FINISH;
        end else if (last_cnt) begin
          resync_d = 1'b1;
          pp_d     = start_q;
          state_d  = ST_FINISH;
        end else begin
          chk_d = next_slot(chk_q);
          cnt_d = cnt_q + PW'(1);
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pp_q        <= '0;
      last_q      <= '0;
      resync_q    <= 1'b1;
      sig_q       <= SIGNATURE_RST;
      frame_q     <= FRAME_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pp_q        <= pp_d;
      last_q      <= last_d;
      resync_q    <= resync_d;
      sig_q       <= sig_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    chk_q       <= chk_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
    size_q      <= size_d;
    hdl_q       <= hdl_d;
    res_acc_q   <= res_acc_d;
    res_rep_q   <= res_rep_d;
    res_old_q   <= res_old_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    res_hdl_q   <= res_hdl_d;
    res_copy_q  <= res_copy_d;
    acc_q       <= acc_d;
    rep_q       <= rep_d;
    old_q       <= old_d;
    found_q     <= found_d;
    slot_q      <= slot_d;
    phdl_q      <= phdl_d;
    copy_q      <= copy_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign replaced_o    = rep_q;
  assign old_handle_o  = old_q;
  assign found_o       = found_q;
  assign slot_index_o  = slot_q;
  assign play_handle_o = phdl_q;
  assign copy_bytes_o  = copy_q;

  a_no_mixed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && accepted_o))
    else $error("Result reports both an arrival and a playout.");

  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (slot_index_o == '0 && play_handle_o == '0 && copy_bytes_o == '0))
    else $error("Silence result carries playout fields.");

  a_no_replace_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !replaced_o) |-> (old_handle_o == '0))
    else $error("Old handle reported without a replacement.");

  a_scan_starts_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == '0) |-> (chk_q == start_q))
    else $error("Scan does not begin at the start slot.");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FINISH))
    else $error("Result presented outside the finish step.");

endmodule
